// File: design/assert_macros.svh
// assertion macros used by the packet generator core
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: design/ttpg_pkg.sv
// shared types, constants and the hamming 8/4 code table
// no dependencies
`timescale 1ns / 1ps

package ttpg_pkg;

    localparam int PACKET_BYTES = 45;
    localparam int HEADER_BYTES = 13;

    localparam int OP_W       = 2;
    localparam int MAG_W      = 3;
    localparam int ROW_W      = 5;
    localparam int PAGE_W     = 8;
    localparam int SUB_W      = 13;
    localparam int CTL_W      = 15;
    localparam int DES_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 6;

    localparam logic [INDEX_W-1:0] LAST_FULL   = INDEX_W'(PACKET_BYTES - 1);
    localparam logic [INDEX_W-1:0] LAST_HEADER = INDEX_W'(HEADER_BYTES - 1);

    localparam logic [BYTE_W-1:0] RUN_IN  = 8'h55;
    localparam logic [BYTE_W-1:0] FRAMING = 8'h27;
    localparam logic [BYTE_W-1:0] SPACE   = 8'h20;

    localparam logic [MAG_W-1:0] FILLER_MAG = 3'd0;
    localparam logic [ROW_W-1:0] FILLER_ROW = 5'd25;
    localparam logic [ROW_W-1:0] HEADER_ROW = 5'd0;

    typedef enum logic [OP_W-1:0] {
        OP_HEADER  = 2'd0,
        OP_FILLER  = 2'd1,
        OP_QUIET   = 2'd2,
        OP_ENHANCE = 2'd3
    } t_opcode;

    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

    localparam logic [BYTE_W-1:0] HAM84 [16] = '{
        8'h15, 8'h02, 8'h49, 8'h5E, 8'h64, 8'h73, 8'h38, 8'h2F,
        8'hD0, 8'hC7, 8'h8C, 8'h9B, 8'hA1, 8'hB6, 8'hFD, 8'hEA
    };

    function automatic logic [BYTE_W-1:0] ham84(input logic [3:0] nib);
        return HAM84[nib];
    endfunction

endpackage

// File: design/ttpg_req_if.sv
// request channel: one packet request per beat
// depends on ttpg_pkg
`timescale 1ns / 1ps

interface ttpg_req_if import ttpg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [MAG_W-1:0]   magazine;
    logic [ROW_W-1:0]   row_number;
    logic [PAGE_W-1:0]  page_number;
    logic [SUB_W-1:0]   sub_code;
    logic [CTL_W-1:0]   control_flags;
    logic [DES_W-1:0]   designation;

    modport source (
        output valid, opcode, magazine, row_number, page_number, sub_code,
               control_flags, designation,
        input  ready
    );
    modport sink (
        input  valid, opcode, magazine, row_number, page_number, sub_code,
               control_flags, designation,
        output ready
    );
endinterface

// File: design/ttpg_byte_if.sv
// output channel: one packet byte per beat
// depends on ttpg_pkg
`timescale 1ns / 1ps

interface ttpg_byte_if import ttpg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   packet_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic                last_byte;

    modport source (
        output valid, packet_byte, byte_index, last_byte,
        input  ready
    );
    modport sink (
        input  valid, packet_byte, byte_index, last_byte,
        output ready
    );
endinterface

// File: design/ttpg_ctrl.sv
// controller: idle / send state machine driving the handshakes
// depends on ttpg_pkg
`timescale 1ns / 1ps

module ttpg_ctrl import ttpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic w_send;
    logic w_done;

    assign w_send = (r_state == S_SEND);
    // final beat leaves this cycle, so a new request can come in behind it
    assign w_done = w_send && i_out_ready && i_status.last;

    assign o_out_valid   = w_send;
    assign o_req_ready   = (r_state == S_IDLE) || w_done;
    assign o_cmd.load    = i_req_valid && o_req_ready;
    assign o_cmd.advance = w_send && i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_SEND;
            end
            S_SEND: begin
                if (o_cmd.load) n_state = S_SEND;
                else if (w_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/ttpg_datapath.sv
// datapath: held request, byte position counter and byte formatter
// depends on ttpg_pkg
`timescale 1ns / 1ps

module ttpg_datapath import ttpg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [MAG_W-1:0]    i_magazine,
    input  logic [ROW_W-1:0]    i_row_number,
    input  logic [PAGE_W-1:0]   i_page_number,
    input  logic [SUB_W-1:0]    i_sub_code,
    input  logic [CTL_W-1:0]    i_control_flags,
    input  logic [DES_W-1:0]    i_designation,
    output t_dp_status          o_status,
    output logic [BYTE_W-1:0]   o_packet_byte,
    output logic [INDEX_W-1:0]  o_byte_index,
    output logic                o_last_byte
);

    t_opcode             r_op;
    logic [MAG_W-1:0]    r_mag;
    logic [ROW_W-1:0]    r_row;
    logic [PAGE_W-1:0]   r_page;
    logic [SUB_W-1:0]    r_sub;
    logic [CTL_W-1:0]    r_ctl;
    logic [DES_W-1:0]    r_des;
    logic [INDEX_W-1:0]  r_pos;
    logic [INDEX_W-1:0]  n_pos;

    logic [MAG_W-1:0]    w_mag;
    logic [ROW_W-1:0]    w_row;
    logic [INDEX_W-1:0]  w_last_idx;
    logic                w_last;
    logic [3:0]          w_nib;
    logic [BYTE_W-1:0]   w_byte;

    // request fields: payload only, loaded on the accepted request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_mag <= i_magazine;
            r_row <= i_row_number;
            r_page <= i_page_number;
            r_sub <= i_sub_code;
            r_ctl <= i_control_flags;
            r_des <= i_designation;
        end
    end

    assign w_last_idx = (r_op == OP_HEADER) ? LAST_HEADER : LAST_FULL;
    assign w_last     = (r_pos == w_last_idx);

    always_comb begin
        n_pos = r_pos;
        if (i_cmd.load) n_pos = '0;
        else if (i_cmd.advance) n_pos = w_last ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // mrag source: filler forces magazine 0 / row 25, header is row 0
    always_comb begin
        w_mag = r_mag;
        w_row = r_row;
        case (r_op)
            OP_FILLER: begin
                w_mag = FILLER_MAG;
                w_row = FILLER_ROW;
            end
            OP_HEADER:  w_row = HEADER_ROW;
            default:    ;
        endcase
    end

    // nibble to code for the header body bytes
    always_comb begin
        case (r_pos)
            6'd5:    w_nib = r_page[3:0];
            6'd6:    w_nib = r_page[7:4];
            6'd7:    w_nib = r_sub[3:0];
            6'd8:    w_nib = {r_ctl[14], r_sub[6:4]};
            6'd9:    w_nib = r_sub[10:7];
            6'd10:   w_nib = {r_ctl[1], r_ctl[0], r_sub[12:11]};
            6'd11:   w_nib = r_ctl[5:2];
            6'd12:   w_nib = {r_ctl[9:7], r_ctl[6]};
            default: w_nib = '0;
        endcase
    end

    always_comb begin
        w_byte = '0;
        if (r_op != OP_QUIET) begin
            case (r_pos)
                6'd0, 6'd1: w_byte = RUN_IN;
                6'd2:       w_byte = FRAMING;
                6'd3:       w_byte = ham84({w_row[0], w_mag});
                6'd4:       w_byte = ham84(w_row[4:1]);
                default: begin
                    case (r_op)
                        OP_HEADER:  w_byte = ham84(w_nib);
                        OP_FILLER:  w_byte = SPACE;
                        OP_ENHANCE: w_byte = (r_pos == 6'd5) ? ham84(r_des) : '0;
                        default:    w_byte = '0;
                    endcase
                end
            endcase
        end
    end

    assign o_status.last = w_last;
    assign o_packet_byte = w_byte;
    assign o_byte_index  = r_pos;
    assign o_last_byte   = w_last;

endmodule

// File: design/teletext_packet_prefix_generator_core.sv
// Teletext packet generator: one request in, 13 (header) or 45 bytes out.
// The first byte is valid in the cycle after the request beat.
// Throughput: one byte per cycle while the receiver is ready; the byte position
// counter ends each packet, and the next request is taken with the final byte beat.
// Reset (synchronous, active low) returns the controller to idle with the
// position counter at zero; no byte is pending after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module teletext_packet_prefix_generator_core import ttpg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttpg_req_if.sink     i_req,
    ttpg_byte_if.source  o_byte
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ttpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_out_valid (o_byte.valid),
        .i_out_ready (o_byte.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ttpg_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (i_req.opcode),
        .i_magazine      (i_req.magazine),
        .i_row_number    (i_req.row_number),
        .i_page_number   (i_req.page_number),
        .i_sub_code      (i_req.sub_code),
        .i_control_flags (i_req.control_flags),
        .i_designation   (i_req.designation),
        .o_status        (w_status),
        .o_packet_byte   (o_byte.packet_byte),
        .o_byte_index    (o_byte.byte_index),
        .o_last_byte     (o_byte.last_byte)
    );

    `ASSERT_NEXT(a_req_starts_packet, i_clk, i_rst_n, i_req.valid && i_req.ready, o_byte.valid && o_byte.byte_index == '0, "request beat did not start a packet")
    `ASSERT_NEXT(a_index_steps, i_clk, i_rst_n, o_byte.valid && o_byte.ready && !o_byte.last_byte, o_byte.valid && o_byte.byte_index == $past(o_byte.byte_index) + 1'b1, "byte index did not step by one")
    `ASSERT_NEXT(a_last_wraps, i_clk, i_rst_n, o_byte.valid && o_byte.ready && o_byte.last_byte, !o_byte.valid || o_byte.byte_index == '0, "packet continued past its final byte")
    `ASSERT_IMPLIES(a_last_position, i_clk, i_rst_n, o_byte.valid && o_byte.last_byte, o_byte.byte_index == LAST_HEADER || o_byte.byte_index == LAST_FULL, "final byte at an unexpected index")

endmodule

// File: bench/testbench.sv
// testbench for teletext_packet_prefix_generator_core: drives packet requests,
// predicts every packet byte and checks the byte stream under random stalls
// depends on ttpg_pkg, ttpg_req_if, ttpg_byte_if and the core
`timescale 1ns / 1ps

module testbench;
    import ttpg_pkg::*;

    localparam int  DRAIN_TAIL = 8;
    localparam int  LONG_HOLD  = 300;
    localparam int  PRINT_CAP  = 50;
    localparam real RUN_LIMIT  = 10_000_000.0;

    // hamming 8/4 codes of the sixteen nibble values
    localparam logic [7:0] HAM_CODE [16] = '{
        8'h15, 8'h02, 8'h49, 8'h5E, 8'h64, 8'h73, 8'h38, 8'h2F,
        8'hD0, 8'hC7, 8'h8C, 8'h9B, 8'hA1, 8'hB6, 8'hFD, 8'hEA
    };

    typedef struct {
        t_opcode            opcode;
        logic [MAG_W-1:0]   magazine;
        logic [ROW_W-1:0]   row_number;
        logic [PAGE_W-1:0]  page_number;
        logic [SUB_W-1:0]   sub_code;
        logic [CTL_W-1:0]   control_flags;
        logic [DES_W-1:0]   designation;
    } t_packet_request;

    typedef struct {
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_packet_byte;

    logic clk = 1'b0;
    logic rst_n;

    t_packet_byte expected_bytes [$];
    int           mismatch_count = 0;
    bit           src_idle_en  = 1'b1;
    bit           sink_idle_en = 1'b1;
    bit           long_hold_req = 1'b0;

    ttpg_req_if  req_bus ();
    ttpg_byte_if byte_bus ();

    teletext_packet_prefix_generator_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_byte  (byte_bus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // expected byte stream of one packet request
    function automatic void predict_packet_bytes(input t_packet_request r);
        logic [BYTE_W-1:0] pkt [PACKET_BYTES];
        logic [MAG_W-1:0]  mag;
        logic [ROW_W-1:0]  row;
        logic [CTL_W-1:0]  ctl;
        logic [SUB_W-1:0]  sub;
        t_packet_byte      b;
        int                count;
        int                k;
        count = PACKET_BYTES;
        mag   = r.magazine;
        row   = r.row_number;
        ctl   = r.control_flags;
        sub   = r.sub_code;
        for (k = 0; k < PACKET_BYTES; k++)
            pkt[k] = (r.opcode == OP_FILLER) ? SPACE : 8'h00;
        case (r.opcode)
            OP_HEADER: begin
                count = HEADER_BYTES;
                row   = HEADER_ROW;
            end
            OP_FILLER: begin
                mag = FILLER_MAG;
                row = FILLER_ROW;
            end
            default: ;
        endcase
        if (r.opcode != OP_QUIET) begin
            pkt[0] = RUN_IN;
            pkt[1] = RUN_IN;
            pkt[2] = FRAMING;
            pkt[3] = HAM_CODE[{row[0], mag}];
            pkt[4] = HAM_CODE[row[4:1]];
        end
        if (r.opcode == OP_HEADER) begin
            pkt[5]  = HAM_CODE[r.page_number[3:0]];
            pkt[6]  = HAM_CODE[r.page_number[7:4]];
            pkt[7]  = HAM_CODE[sub[3:0]];
            // erase flag rides on top of S2
            pkt[8]  = HAM_CODE[{ctl[14], sub[6:4]}];
            pkt[9]  = HAM_CODE[sub[10:7]];
            pkt[10] = HAM_CODE[{ctl[1], ctl[0], sub[12:11]}];
            pkt[11] = HAM_CODE[ctl[5:2]];
            pkt[12] = HAM_CODE[ctl[9:6]];
        end else if (r.opcode == OP_ENHANCE) begin
            pkt[5] = HAM_CODE[r.designation];
        end
        for (k = 0; k < count; k++) begin
            b.data  = pkt[k];
            b.index = INDEX_W'(k);
            b.last  = (k == count - 1);
            expected_bytes.push_back(b);
        end
    endfunction

    function automatic t_packet_request random_request();
        t_packet_request r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.opcode = OP_HEADER;
        else if (pick < 70) r.opcode = OP_ENHANCE;
        else if (pick < 85) r.opcode = OP_FILLER;
        else                r.opcode = OP_QUIET;
        r.magazine      = MAG_W'($urandom);
        r.row_number    = ROW_W'($urandom);
        r.page_number   = PAGE_W'($urandom);
        r.sub_code      = SUB_W'($urandom);
        r.control_flags = CTL_W'($urandom);
        r.designation   = DES_W'($urandom);
        return r;
    endfunction

    task automatic drive_request(input t_packet_request r);
        req_bus.opcode        <= r.opcode;
        req_bus.magazine      <= r.magazine;
        req_bus.row_number    <= r.row_number;
        req_bus.page_number   <= r.page_number;
        req_bus.sub_code      <= r.sub_code;
        req_bus.control_flags <= r.control_flags;
        req_bus.designation   <= r.designation;
    endtask

    // valid stays high into the next request unless a gap is taken
    task automatic send_request(input t_packet_request r);
        int gap;
        if (src_idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 18);
            req_bus.valid <= 1'b0;
            drive_request(random_request());
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        drive_request(r);
        do @(posedge clk); while (!(rst_n && req_bus.ready));
        predict_packet_bytes(r);
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic test_directed_packets();
        send_request('{OP_HEADER, 3'd0, 5'd0, 8'h00, 13'h0000, 15'h0000, 4'h0});
        send_request('{OP_HEADER, 3'd7, 5'd0, 8'hFF, 13'h1FFF, 15'h7FFF, 4'h0});
        send_request('{OP_HEADER, 3'd1, 5'd0, 8'h5A, 13'h1555, 15'h4000, 4'h0});
        send_request('{OP_HEADER, 3'd2, 5'd0, 8'h12, 13'h0000, 15'h0001, 4'h0});
        send_request('{OP_HEADER, 3'd3, 5'd0, 8'h34, 13'h0000, 15'h0002, 4'h0});
        send_request('{OP_HEADER, 3'd4, 5'd0, 8'h56, 13'h0000, 15'h003C, 4'h0});
        send_request('{OP_HEADER, 3'd5, 5'd0, 8'h78, 13'h0000, 15'h0040, 4'h0});
        send_request('{OP_HEADER, 3'd6, 5'd0, 8'h9A, 13'h0000, 15'h0380, 4'h0});
        // row and designation are ignored by a header
        send_request('{OP_HEADER, 3'd0, 5'd31, 8'h90, 13'h0AAA, 15'h3C00, 4'hF});
        send_request('{OP_FILLER, 3'd0, 5'd0, 8'h00, 13'h0000, 15'h0000, 4'h0});
        send_request('{OP_FILLER, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 15'h7FFF, 4'hF});
        send_request('{OP_QUIET, 3'd0, 5'd0, 8'h00, 13'h0000, 15'h0000, 4'h0});
        send_request('{OP_QUIET, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 15'h7FFF, 4'hF});
        send_request('{OP_ENHANCE, 3'd0, 5'd0, 8'h00, 13'h0000, 15'h0000, 4'h0});
        send_request('{OP_ENHANCE, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 15'h7FFF, 4'hF});
        send_request('{OP_ENHANCE, 3'd3, 5'd1, 8'h00, 13'h0000, 15'h0000, 4'h5});
        send_request('{OP_ENHANCE, 3'd5, 5'd30, 8'h00, 13'h0000, 15'h0000, 4'hA});
        send_request('{OP_ENHANCE, 3'd0, 5'd25, 8'h00, 13'h0000, 15'h0000, 4'h8});
        wait_for_drain();
    endtask

    task automatic test_random_packets(input int n_items);
        int i;
        for (i = 0; i < n_items; i++) begin
            // switch idling per chunk so some stretches run clean
            if (i % 25 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_request(random_request());
        end
        wait_for_drain();
    endtask

    task automatic test_output_backpressure();
        int i;
        src_idle_en   = 1'b0;
        long_hold_req = 1'b1;
        for (i = 0; i < 6; i++)
            send_request(random_request());
        wait_for_drain();
    endtask

    task automatic test_back_to_back(input int n_items);
        int i;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (i = 0; i < n_items; i++)
            send_request(random_request());
        wait_for_drain();
    endtask

    // receiver side: ready with random stall bursts, and one long hold on request
    initial begin : sink_driver
        int burst;
        byte_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                byte_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                byte_bus.ready <= 1'b0;
                burst = $urandom_range(1, 18);
                repeat (burst) @(posedge clk);
            end
            byte_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : byte_checker
        t_packet_byte want;
        if (rst_n && byte_bus.valid && byte_bus.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected beat", int'(byte_bus.packet_byte), 0);
            end else begin
                want = expected_bytes.pop_front();
                if (byte_bus.packet_byte !== want.data)
                    report_mismatch($sformatf("packet_byte at index %0d", want.index),
                                    int'(byte_bus.packet_byte), int'(want.data));
                if (byte_bus.byte_index !== want.index)
                    report_mismatch("byte_index", int'(byte_bus.byte_index),
                                    int'(want.index));
                if (byte_bus.last_byte !== want.last)
                    report_mismatch($sformatf("last_byte at index %0d", want.index),
                                    int'(byte_bus.last_byte), int'(want.last));
            end
        end
    end

    initial begin
        #RUN_LIMIT;
        $display("testbench failed");
        $finish;
    end

    initial begin
        rst_n                 = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.opcode        = '0;
        req_bus.magazine      = '0;
        req_bus.row_number    = '0;
        req_bus.page_number   = '0;
        req_bus.sub_code      = '0;
        req_bus.control_flags = '0;
        req_bus.designation   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_packets();
        test_random_packets(100);
        test_output_backpressure();
        test_back_to_back(30);

        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
